// ===== src/inversion_counter_assert.svh =====
// assertion macros used by the top-level rtl file
`ifndef INVERSION_COUNTER_ASSERT_SVH
`define INVERSION_COUNTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("inversion_counter: same-cycle check failed");

// next-cycle implication, checked out of reset
`define IC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("inversion_counter: next-cycle check failed");

`endif

// ===== src/ic_pkg.sv =====
`default_nettype none

package ic_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 19;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned MAX_LEN_DEF = 1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_RUN,
    ST_READ,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic load;        // store one beat
    logic init;        // last beat: set up the first pass
    logic pass_start;  // first run of a pass
    logic run_setup;   // compute run bounds
    logic run_next;    // step to the next run pair
    logic pass_next;   // double the run width, swap memories
    logic merge;       // move one element
    logic emit;        // load the result register
  } ic_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic runs_done;
    logic run_done;
    logic out_free;
  } ic_sts_t;

endpackage

`default_nettype wire

// ===== src/inversion_counter.sv =====
// channel   dir  tdata                           tuser       tlast
// s_axis    in   [31:0] value (signed)           -           last element
// m_axis    out  [18:0] inversion_count, pad 0   overflow    -
//
// loading accepts one beat per cycle; after the last beat the sort runs
// ceil(log2 n) merge passes, and every merged element needs a registered
// read of both run heads then one write
// rst_ni clears control state only; element memories are not cleared
// the result waits in an output register, so a stalled m_axis only holds
// the block when the next result is ready before the previous one is taken

`default_nettype none

module inversion_counter
  import ic_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [DATA_W-1:0]      s_axis_tdata,  // [31:0] value
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [18:0] inversion_count
  output logic                        m_axis_tuser   // [0] overflow
);

  ic_cmd_t            cmd;
  ic_sts_t            sts;
  logic [COUNT_W-1:0] count;

  ic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ic_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_value_i     (s_axis_tdata),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_count_o    (count),
    .out_overflow_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - COUNT_W){1'b0}}, count};

`include "inversion_counter_assert.svh"

  `IC_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  `IC_ASSERT_SAME(a_merge_in_run, cmd.merge, !sts.run_done)
  `IC_ASSERT_NEXT(a_emit_shows, cmd.emit, m_axis_tvalid)

endmodule

`default_nettype wire

// ===== src/ic_ctrl.sv =====
`default_nettype none

module ic_ctrl
  import ic_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_last_i,
  output logic         in_ready_o,
  input  wire ic_sts_t sts_i,
  output ic_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.init = 1'b1;
            state_d    = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (sts_i.sort_done) begin
          // wait for room in the result register
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = ST_LOAD;
          end
        end else begin
          cmd_o.pass_start = 1'b1;
          state_d          = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.runs_done) begin
          cmd_o.pass_next = 1'b1;
          state_d         = ST_PASS;
        end else begin
          cmd_o.run_setup = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_READ: begin
        // memory read of both heads is in flight this cycle
        if (sts_i.run_done) begin
          cmd_o.run_next = 1'b1;
          state_d        = ST_RUN;
        end else begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = ST_READ;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/ic_dpath.sv =====
`default_nettype none

module ic_dpath
  import ic_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ic_cmd_t                  cmd_i,
  output ic_sts_t                       sts_o,
  input  wire logic signed [DATA_W-1:0] in_value_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic [COUNT_W-1:0]            out_count_o,
  output logic                          out_overflow_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned SW = ((IW > COUNT_W) ? IW : COUNT_W) + 1;

  // ping-pong element memories
  logic signed [DATA_W-1:0] mem0 [MAX_LEN];
  logic signed [DATA_W-1:0] mem1 [MAX_LEN];
  logic signed [DATA_W-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

  logic [CW-1:0]      n_q;
  logic               ovf_q;
  logic [IW-1:0]      width_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
  logic               pass_q;
  logic [COUNT_W-1:0] total_q;
  logic               out_valid_q, out_ovf_q;
  logic [COUNT_W-1:0] out_count_q;

  logic [IW-1:0]            n_ext, lo_w, lo_2w, mid_new, hi_new, left_cnt;
  logic                     has_room, a_done, b_done, take_a;
  logic signed [DATA_W-1:0] da, db, merged, wr0_data;
  logic [SW-1:0]            sum;
  logic                     wr0_en, wr1_en;
  logic [AW-1:0]            wr0_addr;

  assign n_ext    = IW'(n_q);
  assign has_room = n_q < CW'(MAX_LEN);
  assign lo_w     = lo_q + width_q;
  assign lo_2w    = lo_q + (width_q << 1);
  assign mid_new  = (lo_w < n_ext) ? lo_w : n_ext;
  assign hi_new   = (lo_2w < n_ext) ? lo_2w : n_ext;

  // source is mem0 on even passes
  assign da       = pass_q ? rd1a_q : rd0a_q;
  assign db       = pass_q ? rd1b_q : rd0b_q;
  assign a_done   = a_q == mid_q;
  assign b_done   = b_q == hi_q;
  assign take_a   = !a_done && (b_done || (da <= db));
  assign merged   = take_a ? da : db;
  assign left_cnt = mid_q - a_q;
  assign sum      = SW'(total_q) + SW'(left_cnt);

  assign wr0_en   = (cmd_i.load && has_room) || (cmd_i.merge && pass_q);
  assign wr1_en   = cmd_i.merge && !pass_q;
  assign wr0_addr = cmd_i.load ? n_q[AW-1:0] : k_q[AW-1:0];
  assign wr0_data = cmd_i.load ? in_value_i : merged;

  always_ff @(posedge clk_i) begin
    if (wr0_en) begin
      mem0[wr0_addr] <= wr0_data;
    end
    if (wr1_en) begin
      mem1[k_q[AW-1:0]] <= merged;
    end
    rd0a_q <= mem0[a_q[AW-1:0]];
    rd0b_q <= mem0[b_q[AW-1:0]];
    rd1a_q <= mem1[a_q[AW-1:0]];
    rd1b_q <= mem1[b_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      ovf_q       <= 1'b0;
      width_q     <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      pass_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (has_room) begin
          n_q <= n_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.init) begin
        width_q <= IW'(1);
        pass_q  <= 1'b0;
        total_q <= '0;
      end
      if (cmd_i.pass_start) begin
        lo_q <= '0;
      end
      if (cmd_i.run_setup) begin
        mid_q <= mid_new;
        hi_q  <= hi_new;
        a_q   <= lo_q;
        b_q   <= mid_new;
        k_q   <= lo_q;
      end
      if (cmd_i.run_next) begin
        lo_q <= lo_2w;
      end
      if (cmd_i.pass_next) begin
        width_q <= width_q << 1;
        pass_q  <= !pass_q;
      end
      if (cmd_i.merge) begin
        k_q <= k_q + 1'b1;
        if (take_a) begin
          a_q <= a_q + 1'b1;
        end else begin
          b_q <= b_q + 1'b1;
          // every element left in the lower run is greater
          total_q <= (sum > SW'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        n_q         <= '0;
        ovf_q       <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_count_q <= total_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign sts_o.sort_done = width_q >= n_ext;
  assign sts_o.runs_done = lo_q >= n_ext;
  assign sts_o.run_done  = k_q == hi_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_count_o    = out_count_q;
  assign out_overflow_o = out_ovf_q;

endmodule

`default_nettype wire
